>>> rtl/core/assert_macros.svh
// Assertion helper macros shared by the maze carver RTL.
// Needs clk_i and rst_ni in the scope of each use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define RDMC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define RDMC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

>>> rtl/core/rdmc_pkg.sv
// Types, codes and defaults for the maze carver.
// No dependencies; used by every module of the block except rdmc_mod_unit.
package rdmc_pkg;

  localparam int unsigned GRID_SIDE_DEF   = 64;
  localparam int unsigned STACK_DEPTH_DEF = 1024;

  localparam logic [5:0] ROWS_RESET = 6'd21;
  localparam logic [5:0] COLS_RESET = 6'd21;

  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;

  localparam logic [1:0] CELL_WALL = 2'd0;
  localparam logic [1:0] CELL_FREE = 2'd1;
  localparam logic [1:0] CELL_SEEN = 2'd2;

  typedef enum logic [1:0] {
    OP_INIT = 2'd0,
    OP_STEP = 2'd1,
    OP_READ = 2'd2,
    OP_NOP  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_CARVED = 2'd0,
    ST_DEAD   = 2'd1,
    ST_EMPTY  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    DIR_NONE  = 3'd0,
    DIR_RIGHT = 3'd1,
    DIR_DOWN  = 3'd2,
    DIR_LEFT  = 3'd3,
    DIR_UP    = 3'd4
  } dir_e;

  typedef struct packed {
    op_e         opcode;
    logic [15:0] random_word;
    logic [5:0]  query_row;
    logic [5:0]  query_col;
  } req_t;

  typedef struct packed {
    status_e    status;
    logic [5:0] cell_row;
    logic [5:0] cell_col;
    dir_e       carve_direction;
    logic       cell_open;
  } rsp_t;

  // neighbor unit result
  typedef struct packed {
    logic [5:0] row;
    logic [5:0] col;
    logic       allowed;
    logic       in_grid;
  } nbr_t;

endpackage

>>> rtl/core/rdmc_nbr_unit.sv
// Shared neighbor unit: steps a cell one or two places in a direction,
// applies the border rules and forms the grid address. Uses rdmc_pkg.
module rdmc_nbr_unit #(
  parameter int unsigned GRID_SIDE = rdmc_pkg::GRID_SIDE_DEF,
  localparam int unsigned GAW = $clog2(GRID_SIDE * GRID_SIDE)
) (
  input  logic [5:0]       row_i,
  input  logic [5:0]       col_i,
  input  rdmc_pkg::dir_e   dir_i,
  input  logic             far_i,
  input  logic [5:0]       rows_i,
  input  logic [5:0]       cols_i,
  output rdmc_pkg::nbr_t   res_o,
  output logic [GAW-1:0]   addr_o
);
  import rdmc_pkg::*;

  logic signed [7:0] r, c, rs, cs, step, dr, dc, nr, nc;
  logic              allowed;

  always_comb begin
    r    = signed'({2'b00, row_i});
    c    = signed'({2'b00, col_i});
    rs   = signed'({2'b00, rows_i});
    cs   = signed'({2'b00, cols_i});
    step = far_i ? 8'sd2 : 8'sd1;
    dr   = 8'sd0;
    dc   = 8'sd0;
    allowed = 1'b1;
    unique case (dir_i)
      DIR_RIGHT: begin
        dc = step;
        allowed = (c != cs - 8'sd2) && (c != cs - 8'sd3) && (c + 8'sd2 < cs);
      end
      DIR_DOWN: begin
        dr = step;
        allowed = (r != rs - 8'sd2) && (r != rs - 8'sd3) && (r + 8'sd2 < rs);
      end
      DIR_LEFT: begin
        dc = -step;
        allowed = (c >= 8'sd3);
      end
      DIR_UP: begin
        dr = -step;
        allowed = (r >= 8'sd3);
      end
      default: ;
    endcase
    nr = r + dr;
    nc = c + dc;
  end

  assign res_o.row     = nr[5:0];
  assign res_o.col     = nc[5:0];
  assign res_o.allowed = allowed;
  assign res_o.in_grid = (nr >= 8'sd0) && (nc >= 8'sd0) &&
                         (int'(nr) < int'(GRID_SIDE)) && (int'(nc) < int'(GRID_SIDE));
  assign addr_o = GAW'(int'(nr) * int'(GRID_SIDE) + int'(nc));

endmodule

>>> rtl/core/rdmc_mod_unit.sv
// Remainder of the random word by a candidate count of one to four.
// No dependencies.
module rdmc_mod_unit (
  input  logic [15:0] word_i,
  input  logic [2:0]  count_i,
  output logic [1:0]  rem_o
);

  logic [4:0] s1;
  logic [2:0] s2, s3;

  // 4^k = 1 mod 3, so base-4 digit sums keep the remainder
  always_comb begin
    s1 = '0;
    for (int i = 0; i < 8; i++) begin
      s1 = s1 + 5'(word_i[2*i +: 2]);
    end
    s2 = 3'(s1[1:0]) + 3'(s1[3:2]) + 3'(s1[4]);
    s3 = 3'(s2[1:0]) + 3'(s2[2]);
    case (count_i)
      3'd2:    rem_o = {1'b0, word_i[0]};
      3'd3:    rem_o = (s3 >= 3'd3) ? 2'(s3 - 3'd3) : s3[1:0];
      3'd4:    rem_o = word_i[1:0];
      default: rem_o = 2'd0;
    endcase
  end

endmodule

>>> rtl/core/random_dfs_maze_carver.sv
// Step: one grid read port is probed once per neighbor through the shared
// unit. Init: writes all GRID_SIDE*GRID_SIDE grid entries, one per cycle.
// One transaction at a time.
// Reset clears control and the stack count and sets both sizes to 21;
// the grid is undefined until init. Results show for one cycle, no stall.
`include "assert_macros.svh"

module random_dfs_maze_carver #(
  parameter int unsigned GRID_SIDE   = rdmc_pkg::GRID_SIDE_DEF,
  parameter int unsigned STACK_DEPTH = rdmc_pkg::STACK_DEPTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  rdmc_pkg::req_t req_i,
  output logic           done_o,
  output rdmc_pkg::rsp_t rsp_o,
  input  logic           cfg_we_i,
  input  logic           cfg_idx_i,
  input  logic [5:0]     cfg_wdata_i
);
  import rdmc_pkg::*;

  localparam int unsigned GAW  = $clog2(GRID_SIDE * GRID_SIDE);
  localparam int unsigned SW   = $clog2(GRID_SIDE);
  localparam int unsigned SAW  = $clog2(STACK_DEPTH);
  localparam int unsigned CNTW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_INIT = 7'b0000010,
    S_RDW  = 7'b0000100,
    S_POPW = 7'b0001000,
    S_CHK  = 7'b0010000,
    S_PICK = 7'b0100000,
    S_PUSH = 7'b1000000
  } state_e;

  state_e          state_q, state_d;
  logic [5:0]      rows_q, cols_q, rows_eff, cols_eff;
  logic [CNTW-1:0] count_q, count_d;
  logic [15:0]     rnd_q, rnd_d;
  logic [5:0]      cur_row_q, cur_row_d, cur_col_q, cur_col_d;
  logic [2:0]      k_q, k_d, n_q, n_d;
  dir_e            dirs_q [4];
  dir_e            dirs_d [4];
  dir_e            dsel_q, dsel_d;
  logic            allowed_q, allowed_d;
  logic [SW-1:0]   sw_row_q, sw_row_d, sw_col_q, sw_col_d;
  logic [GAW-1:0]  sw_addr_q, sw_addr_d;
  logic            done_q, done_d;
  rsp_t            rsp_q, rsp_d;

  // shared unit hookup
  logic [5:0]      u_row, u_col;
  dir_e            u_dir;
  logic            u_far;
  nbr_t            u_res;
  logic [GAW-1:0]  u_addr;
  logic [1:0]      rem;

  // memories
  logic [1:0]      grid_mem [GRID_SIDE*GRID_SIDE];
  logic [11:0]     stack_mem [STACK_DEPTH];
  logic            grid_we;
  logic [GAW-1:0]  grid_waddr;
  logic [1:0]      grid_wdata;
  logic [1:0]      grid_rdata_q;
  logic            stack_we;
  logic [SAW-1:0]  stack_waddr, stack_raddr;
  logic [11:0]     stack_wdata, stack_rdata_q;

  logic            sw_free, sw_open, sw_last;
  int              swr, swc, rws, cls;

  assign rows_eff = (int'(rows_q) < int'(GRID_SIDE)) ? rows_q : 6'(GRID_SIDE);
  assign cols_eff = (int'(cols_q) < int'(GRID_SIDE)) ? cols_q : 6'(GRID_SIDE);

  rdmc_nbr_unit #(.GRID_SIDE(GRID_SIDE)) u_nbr (
    .row_i  (u_row),
    .col_i  (u_col),
    .dir_i  (u_dir),
    .far_i  (u_far),
    .rows_i (rows_eff),
    .cols_i (cols_eff),
    .res_o  (u_res),
    .addr_o (u_addr)
  );

  rdmc_mod_unit u_mod (
    .word_i  (rnd_q),
    .count_i (n_q),
    .rem_o   (rem)
  );

  // init sweep cell value
  always_comb begin
    swr = int'(sw_row_q);
    swc = int'(sw_col_q);
    rws = int'(rows_eff);
    cls = int'(cols_eff);
    sw_open = (swr == 1 && swc == 0) || (swr == rws - 2 && swc == cls - 1);
    sw_free = swr[0] && (swr < rws) && (swc < cls) && (sw_open || swc[0]);
    sw_last = (swr == int'(GRID_SIDE) - 1) && (swc == int'(GRID_SIDE) - 1);
  end

  assign busy   = (state_q != S_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    rnd_d     = rnd_q;
    cur_row_d = cur_row_q;
    cur_col_d = cur_col_q;
    k_d       = k_q;
    n_d       = n_q;
    dirs_d    = dirs_q;
    dsel_d    = dsel_q;
    allowed_d = allowed_q;
    sw_row_d  = sw_row_q;
    sw_col_d  = sw_col_q;
    sw_addr_d = sw_addr_q;
    done_d    = 1'b0;
    rsp_d     = rsp_q;

    u_row = cur_row_q;
    u_col = cur_col_q;
    u_dir = DIR_NONE;
    u_far = 1'b0;

    grid_we     = 1'b0;
    grid_waddr  = u_addr;
    grid_wdata  = CELL_FREE;
    stack_we    = 1'b0;
    stack_waddr = count_q[SAW-1:0];
    stack_wdata = {cur_row_q, cur_col_q};
    stack_raddr = SAW'(count_q - CNTW'(1));

    unique case (state_q)
      S_IDLE: begin
        u_row = req_i.query_row;
        u_col = req_i.query_col;
        if (start) begin
          rnd_d = req_i.random_word;
          rsp_d = '0;
          unique case (req_i.opcode)
            OP_INIT: begin
              sw_row_d  = '0;
              sw_col_d  = '0;
              sw_addr_d = '0;
              state_d   = S_INIT;
            end
            OP_STEP: begin
              if (count_q == '0) begin
                rsp_d.status = ST_EMPTY;
                done_d       = 1'b1;
              end else begin
                count_d = count_q - CNTW'(1);
                state_d = S_POPW;
              end
            end
            OP_READ: begin
              rsp_d.cell_row = req_i.query_row;
              rsp_d.cell_col = req_i.query_col;
              allowed_d      = u_res.in_grid;
              state_d        = S_RDW;
            end
            default: done_d = 1'b1;
          endcase
        end
      end
      S_INIT: begin
        grid_we    = 1'b1;
        grid_waddr = sw_addr_q;
        grid_wdata = sw_free ? CELL_FREE : CELL_WALL;
        sw_addr_d  = sw_addr_q + GAW'(1);
        if (int'(sw_col_q) == int'(GRID_SIDE) - 1) begin
          sw_col_d = '0;
          sw_row_d = sw_row_q + SW'(1);
        end else begin
          sw_col_d = sw_col_q + SW'(1);
        end
        if (sw_last) begin
          stack_we    = 1'b1;
          stack_waddr = '0;
          stack_wdata = {6'd1, 6'd1};
          count_d     = CNTW'(1);
          done_d      = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_RDW: begin
        rsp_d.cell_open = allowed_q && (grid_rdata_q != CELL_WALL);
        done_d          = 1'b1;
        state_d         = S_IDLE;
      end
      S_POPW: begin
        u_row      = stack_rdata_q[11:6];
        u_col      = stack_rdata_q[5:0];
        cur_row_d  = stack_rdata_q[11:6];
        cur_col_d  = stack_rdata_q[5:0];
        grid_we    = u_res.in_grid;
        grid_wdata = CELL_SEEN;
        k_d        = '0;
        n_d        = '0;
        state_d    = S_CHK;
      end
      S_CHK: begin
        // probe direction code k+1, judge the probe of direction code k
        u_dir     = dir_e'(3'(k_q + 3'd1));
        u_far     = 1'b1;
        allowed_d = u_res.allowed && u_res.in_grid && (k_q != 3'd4);
        if (k_q != 3'd0 && allowed_q && grid_rdata_q == CELL_FREE) begin
          dirs_d[n_q[1:0]] = dir_e'(k_q);
          n_d              = n_q + 3'd1;
        end
        k_d = k_q + 3'd1;
        if (k_q == 3'd4) state_d = S_PICK;
      end
      S_PICK: begin
        rsp_d.cell_row = cur_row_q;
        rsp_d.cell_col = cur_col_q;
        if (n_q == 3'd0) begin
          rsp_d.status = ST_DEAD;
          done_d       = 1'b1;
          state_d      = S_IDLE;
        end else begin
          u_dir    = dirs_q[rem];
          dsel_d   = dirs_q[rem];
          grid_we  = u_res.in_grid;
          if (int'(count_q) < int'(STACK_DEPTH)) begin
            stack_we = 1'b1;
            count_d  = count_q + CNTW'(1);
          end
          state_d = S_PUSH;
        end
      end
      S_PUSH: begin
        u_dir       = dsel_q;
        u_far       = 1'b1;
        stack_wdata = {u_res.row, u_res.col};
        if (int'(count_q) < int'(STACK_DEPTH)) begin
          stack_we = 1'b1;
          count_d  = count_q + CNTW'(1);
        end
        rsp_d.status          = ST_CARVED;
        rsp_d.carve_direction = dsel_q;
        done_d                = 1'b1;
        state_d               = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
      rows_q  <= ROWS_RESET;
      cols_q  <= COLS_RESET;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_ROWS) rows_q <= cfg_wdata_i;
        if (cfg_idx_i == REG_COLS) cols_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rnd_q     <= rnd_d;
    cur_row_q <= cur_row_d;
    cur_col_q <= cur_col_d;
    k_q       <= k_d;
    n_q       <= n_d;
    dirs_q    <= dirs_d;
    dsel_q    <= dsel_d;
    allowed_q <= allowed_d;
    sw_row_q  <= sw_row_d;
    sw_col_q  <= sw_col_d;
    sw_addr_q <= sw_addr_d;
    rsp_q     <= rsp_d;
  end

  always_ff @(posedge clk_i) begin
    if (grid_we) grid_mem[grid_waddr] <= grid_wdata;
    grid_rdata_q <= grid_mem[u_addr];
  end

  always_ff @(posedge clk_i) begin
    if (stack_we) stack_mem[stack_waddr] <= stack_wdata;
    stack_rdata_q <= stack_mem[stack_raddr];
  end

  `RDMC_ASSERT(a_count_bound, count_q <= CNTW'(STACK_DEPTH), "stack count beyond depth")
  `RDMC_ASSERT(a_no_grid_write_in_chk, (state_q == S_CHK) |-> !grid_we,
               "grid written while probing neighbors")
  `RDMC_ASSERT(a_push_result, (state_q == S_PUSH) |=> (done_o && rsp_o.status == ST_CARVED),
               "carve step ended without a carved result")
  `RDMC_ASSERT(a_cand_bound, (state_q == S_PICK) |-> (n_q <= 3'd4),
               "candidate count beyond four")
  `RDMC_ASSERT(a_idle_after_done, done_o |-> (state_q == S_IDLE),
               "result strobe while a transaction is still in flight")

endmodule

>>> bench/random_dfs_maze_carver_checker.sv
// Checker for the maze carver: watches the command, result and register
// channels, predicts each result and compares it. Depends on rdmc_pkg.
module random_dfs_maze_carver_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic           busy_i,
  input  rdmc_pkg::req_t req_i,
  input  logic           done_i,
  input  rdmc_pkg::rsp_t rsp_i,
  input  logic           cfg_we_i,
  input  logic           cfg_idx_i,
  input  logic [5:0]     cfg_wdata_i,
  output int unsigned    fail_count_o,
  output int unsigned    pending_o
);
  import rdmc_pkg::*;

  localparam int SIDE  = GRID_SIDE_DEF;
  localparam int DEPTH = STACK_DEPTH_DEF;

  logic [1:0]  cell_map [SIDE][SIDE];
  int          trail_row [DEPTH];
  int          trail_col [DEPTH];
  int          trail_len;
  int          rows_cfg;
  int          cols_cfg;
  rsp_t        expected_q [$];
  rsp_t        want;
  int unsigned n_fail;

  function automatic logic [1:0] cell_at(int r, int c);
    if (r < 0 || c < 0 || r >= SIDE || c >= SIDE) return CELL_WALL;
    return cell_map[r][c];
  endfunction

  function automatic void cell_put(int r, int c, logic [1:0] v);
    if (r < 0 || c < 0 || r >= SIDE || c >= SIDE) return;
    cell_map[r][c] = v;
  endfunction

  // pushes onto a full stack are dropped
  function automatic void trail_push(int r, int c);
    if (trail_len >= DEPTH) return;
    trail_row[trail_len] = r;
    trail_col[trail_len] = c;
    trail_len++;
  endfunction

  function automatic void lay_out_grid();
    int rows;
    int cols;
    rows = rows_cfg < SIDE ? rows_cfg : SIDE;
    cols = cols_cfg < SIDE ? cols_cfg : SIDE;
    for (int r = 0; r < SIDE; r++)
      for (int c = 0; c < SIDE; c++) cell_map[r][c] = CELL_WALL;
    // only odd rows hold cells; exit only lands if rows-2 is odd
    for (int r = 1; r < rows; r += 2)
      for (int c = 0; c < cols; c++)
        if ((r == 1 && c == 0) || (r == rows - 2 && c == cols - 1) || c[0])
          cell_put(r, c, CELL_FREE);
    trail_len = 0;
    trail_push(1, 1);
  endfunction

  function automatic rsp_t carve_step(logic [15:0] rnd);
    int   rows;
    int   cols;
    int   r;
    int   c;
    int   n;
    int   pick;
    int   dr;
    int   dc;
    dir_e cand [4];
    dir_e d;
    rsp_t o;
    o    = '0;
    rows = rows_cfg < SIDE ? rows_cfg : SIDE;
    cols = cols_cfg < SIDE ? cols_cfg : SIDE;
    if (trail_len == 0) begin
      o.status = ST_EMPTY;
      return o;
    end
    trail_len--;
    r = trail_row[trail_len];
    c = trail_col[trail_len];
    cell_put(r, c, CELL_SEEN);
    o.cell_row = 6'(r);
    o.cell_col = 6'(c);
    n = 0;
    // border exclusions: right/down also barred at size-2 and size-3
    if (c != cols - 2 && c != cols - 3 && c + 2 < cols && cell_at(r, c + 2) == CELL_FREE) begin
      cand[n] = DIR_RIGHT;
      n++;
    end
    if (r != rows - 2 && r != rows - 3 && r + 2 < rows && cell_at(r + 2, c) == CELL_FREE) begin
      cand[n] = DIR_DOWN;
      n++;
    end
    if (c >= 3 && cell_at(r, c - 2) == CELL_FREE) begin
      cand[n] = DIR_LEFT;
      n++;
    end
    if (r >= 3 && cell_at(r - 2, c) == CELL_FREE) begin
      cand[n] = DIR_UP;
      n++;
    end
    if (n == 0) begin
      o.status = ST_DEAD;
      return o;
    end
    pick = rnd;
    d    = cand[pick % n];
    dr   = 0;
    dc   = 0;
    case (d)
      DIR_RIGHT: dc = 1;
      DIR_DOWN:  dr = 1;
      DIR_LEFT:  dc = -1;
      default:   dr = -1;
    endcase
    cell_put(r + dr, c + dc, CELL_FREE);
    trail_push(r, c);
    trail_push(r + 2 * dr, c + 2 * dc);
    o.status          = ST_CARVED;
    o.carve_direction = d;
    return o;
  endfunction

  function automatic rsp_t predict_maze(req_t rq);
    rsp_t o;
    o = '0;
    case (rq.opcode)
      OP_INIT: lay_out_grid();
      OP_STEP: o = carve_step(rq.random_word);
      OP_READ: begin
        o.cell_row  = rq.query_row;
        o.cell_col  = rq.query_col;
        o.cell_open = cell_at(rq.query_row, rq.query_col) != CELL_WALL;
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic string fmt_rsp(rsp_t x);
    return $sformatf("status %0d row %0d col %0d dir %0d open %0d",
                     x.status, x.cell_row, x.cell_col, x.carve_direction, x.cell_open);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      trail_len = 0;
      rows_cfg  = ROWS_RESET;
      cols_cfg  = COLS_RESET;
      n_fail    = 0;
      expected_q.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      // result first: it belongs to an older transaction than a new accept
      if (done_i === 1'b1) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result with no transaction pending, expected none, actual %s",
                   $time, fmt_rsp(rsp_i));
          n_fail++;
        end else begin
          want = expected_q.pop_front();
          if (rsp_i.status !== want.status || rsp_i.cell_row !== want.cell_row ||
              rsp_i.cell_col !== want.cell_col ||
              rsp_i.carve_direction !== want.carve_direction ||
              rsp_i.cell_open !== want.cell_open) begin
            $display("%0t: maze result mismatch, expected %s, actual %s",
                     $time, fmt_rsp(want), fmt_rsp(rsp_i));
            n_fail++;
          end
        end
      end
      if (cfg_we_i === 1'b1) begin
        if (cfg_idx_i == REG_ROWS) rows_cfg = cfg_wdata_i;
        else cols_cfg = cfg_wdata_i;
      end
      if (start_i === 1'b1 && busy_i === 1'b0) expected_q.push_back(predict_maze(req_i));
      fail_count_o <= n_fail;
      pending_o    <= expected_q.size();
    end
  end

endmodule

>>> bench/random_dfs_maze_carver_tb.sv
// Top of the maze carver bench: clock, reset, commands and register writes.
// Depends on rdmc_pkg, random_dfs_maze_carver and the checker module.
module random_dfs_maze_carver_tb;
  import rdmc_pkg::*;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        start       = 1'b0;
  logic        busy;
  req_t        req_i       = '0;
  logic        done_o;
  rsp_t        rsp_o;
  logic        cfg_we_i    = 1'b0;
  logic        cfg_idx_i   = REG_ROWS;
  logic [5:0]  cfg_wdata_i = '0;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned n_items     = 0;
  int          cur_rows    = 21;
  int          cur_cols    = 21;
  bit          no_idle     = 1'b0;

  random_dfs_maze_carver u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .done_o      (done_o),
    .rsp_o       (rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  random_dfs_maze_carver_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .req_i        (req_i),
    .done_i       (done_o),
    .rsp_i        (rsp_o),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #1 clk_i = ~clk_i;

  initial begin
    #2_500_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic req_t cmd(op_e op, logic [15:0] rw, logic [5:0] qr, logic [5:0] qc);
    req_t rq;
    rq.opcode      = op;
    rq.random_word = rw;
    rq.query_row   = qr;
    rq.query_col   = qc;
    return rq;
  endfunction

  function automatic logic [15:0] rand_word();
    return 16'($urandom_range(0, 65535));
  endfunction

  // mostly inside the maze in use, sometimes anywhere
  function automatic logic [5:0] query_coord(int lim);
    if (lim > 0 && $urandom_range(0, 9) < 7) return 6'($urandom_range(0, lim - 1));
    return 6'($urandom_range(0, 63));
  endfunction

  // mostly small odd sizes, a few large, a few even or tiny
  function automatic int pick_side();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 2 * $urandom_range(2, 7) + 1;
    if (roll < 85) return 2 * $urandom_range(8, 15) + 1;
    if (roll < 93) return 2 * $urandom_range(16, 31) + 1;
    return $urandom_range(0, 63);
  endfunction

  function automatic int idle_len();
    int roll;
    if (no_idle) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 70) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // start stays high across back-to-back transactions
  task automatic send_cmd(req_t rq);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= rq;
    do @(posedge clk_i); while (busy !== 1'b0);
    n_items++;
  endtask

  task automatic drain();
    start <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // caller drains first; registers only change while the block is idle
  task automatic set_size(int rows, int cols);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_ROWS;
    cfg_wdata_i <= 6'(rows);
    @(posedge clk_i);
    cfg_idx_i   <= REG_COLS;
    cfg_wdata_i <= 6'(cols);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_rows = rows;
    cur_cols = cols;
  endtask

  initial begin
    int steps_left;
    int roll;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty stack and no-ops before any init; the grid is not read yet
    send_cmd(cmd(OP_STEP, 16'hFFFF, 6'd0, 6'd0));
    send_cmd('1);
    send_cmd(cmd(OP_NOP, 16'h0000, 6'd0, 6'd0));

    // smallest maze: carve to completion and past it
    drain();
    set_size(5, 5);
    send_cmd(cmd(OP_INIT, 16'hFFFF, 6'h3F, 6'h3F));
    for (int i = 0; i < 9; i++)
      send_cmd(cmd(OP_STEP, i[0] ? 16'hFFFF : 16'h0000, 6'd0, 6'd0));
    send_cmd(cmd(OP_READ, 16'h0000, 6'd1, 6'd0));
    send_cmd(cmd(OP_READ, 16'h0000, 6'd3, 6'd4));
    send_cmd(cmd(OP_READ, 16'hFFFF, 6'd0, 6'd0));
    send_cmd(cmd(OP_READ, 16'hFFFF, 6'd63, 6'd63));
    send_cmd(cmd(OP_READ, 16'h0000, 6'd2, 6'd2));
    send_cmd(cmd(OP_READ, 16'h0000, 6'd1, 6'd1));

    // largest maze
    drain();
    set_size(63, 63);
    send_cmd(cmd(OP_INIT, 16'h0000, 6'd0, 6'd0));
    send_cmd(cmd(OP_STEP, 16'hFFFF, 6'd0, 6'd0));
    send_cmd(cmd(OP_STEP, 16'h0000, 6'd0, 6'd0));
    send_cmd(cmd(OP_READ, 16'h0000, 6'd61, 6'd62));
    send_cmd(cmd(OP_READ, 16'h0000, 6'd62, 6'd62));

    // random mazes: init then mostly steps, with reads, no-ops, restarts and resizes
    while (n_items < 1450) begin
      drain();
      set_size(pick_side(), pick_side());
      no_idle = ($urandom_range(0, 3) == 0);
      send_cmd(cmd(OP_INIT, rand_word(), query_coord(0), query_coord(0)));
      steps_left = 2 * (((cur_rows - 1) / 2) * ((cur_cols - 1) / 2)) + 3;
      if (steps_left > 250) steps_left = 250;
      while (steps_left > 0 && n_items < 1450) begin
        roll = $urandom_range(0, 99);
        if (roll < 75) begin
          send_cmd(cmd(OP_STEP, rand_word(), query_coord(0), query_coord(0)));
          steps_left--;
        end else if (roll < 89) begin
          send_cmd(cmd(OP_READ, rand_word(), query_coord(cur_rows), query_coord(cur_cols)));
        end else if (roll < 92) begin
          send_cmd(cmd(OP_NOP, rand_word(), query_coord(0), query_coord(0)));
        end else if (roll < 94) begin
          send_cmd(cmd(OP_INIT, rand_word(), query_coord(0), query_coord(0)));
        end else if (roll < 96) begin
          // resize in the middle of a maze
          drain();
          set_size(pick_side(), pick_side());
        end else begin
          send_cmd(cmd(OP_STEP, $urandom_range(0, 1) ? 16'hFFFF : 16'h0000,
                       query_coord(0), query_coord(0)));
          steps_left--;
        end
      end
    end

    drain();
    repeat (40) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
